/* hw/rtl/srmp_pkg.sv */
`default_nettype none
package srmp_pkg;

	// field and register widths
	localparam int FREQ_W   = 24;
	localparam int SPD_W    = 16;
	localparam int TGT_W    = 17;
	localparam int ACCEL_W  = 16;
	localparam int MICRO_W  = 9;
	localparam int PERIOD_W = 10;
	localparam int CFG_W    = 10;

	// internal datapath widths
	localparam int MUL_W    = 28;	// shift-add product / partial sum
	localparam int MULB_W   = 10;	// multiplier operand, shifted out lsb first
	localparam int DIV_W    = 28;	// serial divider numerator and denominator
	localparam int DIV_CW   = $clog2(DIV_W + 1);
	localparam int STEP_W   = 28;	// ramp step count
	localparam int INCR_W   = 26;	// signed per-step increment
	localparam int FSUM_W   = 27;	// signed frequency after one step
	localparam int DIFF_W   = 25;	// frequency span magnitude

	localparam logic [MULB_W-1:0]   MS_PER_S  = 10'd1000;
	localparam logic [FREQ_W-1:0]   FREQ_MAX  = 24'hFF_FFFF;
	localparam logic [SPD_W-1:0]    SPEED_MAX = 16'hFFFF;
	localparam logic [MICRO_W-1:0]  MICRO_TOP = 9'd256;

	// configuration register indexes
	localparam logic CFG_MICROSTEPS = 1'b0;
	localparam logic CFG_PERIOD     = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/srmp_div.sv */
`default_nettype none
module srmp_div
	import srmp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] numer,
	input  wire logic [DIV_W-1:0] denom,
	output logic                  done,
	output logic [DIV_W-1:0]      quot,
	output logic [DIV_W-1:0]      rem
);

	// restoring divider, one quotient bit per cycle, numerator shifts out msb first
	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  den_q;
	logic              busy;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    trial_sub;
	logic              fits;

	assign busy      = (cnt_q != '0);
	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == DIV_CW'(1));
			if (start) begin
				cnt_q <= DIV_CW'(DIV_W);
			end else if (busy) begin
				cnt_q <= cnt_q - DIV_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= numer;
			den_q <= denom;
		end else if (busy) begin
			rem_q <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

/* hw/rtl/stepper_speed_ramp.sv */
`default_nettype none
// Linear speed ramp for a step/dir motor driver. Each input transaction is either a one
// millisecond tick (tuser = 0) or a ramp start (tuser = 1) carrying a signed target speed
// in full steps/s and an acceleration in full steps/s^2; every input transaction returns
// exactly one result with the current step frequency (Hz), direction, a done flag and a
// flag that is set when the frequency changed. The datapath has one shared shift-add
// multiplier, one bit of its short operand per cycle, and one restoring divider, one
// quotient bit per cycle. A plain tick goes straight to its result; a tick that applies a
// ramp step applies the per-step increment and then divides the new frequency by the
// microstep count, unless it is the final step, which snaps to the target; a full ramp
// start forms four products, whose length grows with the microstep count and the update
// period, then the step count and the per-step increment divisions; a start that
// finishes at once returns sooner. One transaction is worked on at a time; a finished
// result sits in the output register while the next input transaction is already taken.
// Microsteps of 0 act as 1 and above 256 as 256, an update period of 0 acts as 1.
// Configuration writes are always taken and are meant to arrive while the block is idle.
module stepper_speed_ramp
	import srmp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [39:0]       s_tdata,	// target_speed[16:0], accel_rate[32:17], zero
	input  wire logic              s_tuser,	// op: 0 tick, 1 ramp start
	// result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [31:0]            m_tdata,	// step_frequency[23:0], direction[24],
						// motion_done[25], freq_updated[26], zero
	// configuration writes
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	// sequencer states
	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_MUL_CUR    = 4'd1;	// cur_speed * microsteps
	localparam logic [3:0] ST_MUL_TGT    = 4'd2;	// tgt_speed * microsteps
	localparam logic [3:0] ST_MUL_DV     = 4'd3;	// dv * 1000
	localparam logic [3:0] ST_MUL_DEN    = 4'd4;	// accel * period
	localparam logic [3:0] ST_DIV_STEPS  = 4'd5;	// step count
	localparam logic [3:0] ST_DIV_INCR   = 4'd6;	// per-step increment
	localparam logic [3:0] ST_TICK_FREQ  = 4'd7;	// fold sign, saturate, maybe finish
	localparam logic [3:0] ST_TICK_SPEED = 4'd8;	// freq / microsteps
	localparam logic [3:0] ST_OUT        = 4'd9;

	logic [3:0]          state_q;
	logic                m_tvalid_q;
	logic [MICRO_W-1:0]  micro_q;
	logic [PERIOD_W-1:0] period_q;

	// ramp state
	logic [FREQ_W-1:0]   cur_freq_q;
	logic                cur_dir_q;
	logic [SPD_W-1:0]    cur_speed_q;
	logic [FREQ_W-1:0]   tgt_freq_q;
	logic [SPD_W-1:0]    tgt_speed_q;
	logic                tgt_dir_q;
	logic [INCR_W-1:0]   step_incr_q;
	logic [STEP_W-1:0]   step_total_q;
	logic [STEP_W-1:0]   step_index_q;
	logic [PERIOD_W-1:0] ms_elapsed_q;
	logic                done_q;

	// scratch
	logic [MUL_W-1:0]    mul_a_q;
	logic [MULB_W-1:0]   mul_b_q;
	logic [MUL_W-1:0]    mul_acc_q;
	logic [MUL_W-1:0]    num_q;
	logic [ACCEL_W-1:0]  accel_q;
	logic [FSUM_W-1:0]   fsum_q;
	logic [FREQ_W-1:0]   before_q;
	logic                diff_neg_q;
	logic [FREQ_W-1:0]   out_freq_q;
	logic                out_dir_q;
	logic                out_done_q;
	logic                out_upd_q;

	// divider hookup
	logic                div_start;
	logic [DIV_W-1:0]    div_numer;
	logic [DIV_W-1:0]    div_denom;
	logic                div_done;
	logic [DIV_W-1:0]    div_quot;
	logic [DIV_W-1:0]    div_rem;

	logic                in_acc;
	logic                op_start;
	logic [TGT_W-1:0]    raw_speed;
	logic [TGT_W-1:0]    raw_mag;
	logic [SPD_W-1:0]    tgt_speed_in;
	logic [MICRO_W-1:0]  micro_eff;
	logic [PERIOD_W-1:0] period_eff;
	logic                same_dir;
	logic [TGT_W-1:0]    dv;
	logic [DIFF_W-1:0]   fdiff_mag;
	logic                fdiff_neg;
	logic                mul_done;
	logic                snap_start;
	logic                round_up;
	logic [STEP_W-1:0]   steps_new;
	logic [PERIOD_W-1:0] ms_next;
	logic [FSUM_W-1:0]   cur_ext;
	logic [FSUM_W-1:0]   inc_ext;
	logic [FSUM_W-1:0]   fsum_new;
	logic [FSUM_W-1:0]   fsum_mag;
	logic [FREQ_W-1:0]   fsum_sat;
	logic                last_step;
	logic [INCR_W-1:0]   incr_mag;
	logic [SPD_W-1:0]    speed_sat;
	logic                out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign op_start  = s_tuser;
	assign raw_speed = s_tdata[TGT_W-1:0];
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	// clamp registers into their working ranges
	always_comb begin
		if (micro_q == '0) begin
			micro_eff = MICRO_W'(1);
		end else if (micro_q > MICRO_TOP) begin
			micro_eff = MICRO_TOP;
		end else begin
			micro_eff = micro_q;
		end
	end
	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

	// |target| saturates: -65536 would not fit the speed register
	assign raw_mag      = raw_speed[TGT_W-1] ? (TGT_W'(0) - raw_speed) : raw_speed;
	assign tgt_speed_in = raw_mag[TGT_W-1] ? SPEED_MAX : raw_mag[SPD_W-1:0];

	assign same_dir = (tgt_dir_q == cur_dir_q);

	// speed change: magnitude difference, or sum across a reversal
	always_comb begin
		if (!same_dir) begin
			dv = TGT_W'(tgt_speed_q) + TGT_W'(cur_speed_q);
		end else if (tgt_speed_q >= cur_speed_q) begin
			dv = TGT_W'(tgt_speed_q - cur_speed_q);
		end else begin
			dv = TGT_W'(cur_speed_q - tgt_speed_q);
		end
	end

	always_comb begin
		fdiff_neg = 1'b0;
		if (!same_dir) begin
			fdiff_mag = DIFF_W'(tgt_freq_q) + DIFF_W'(cur_freq_q);
		end else if (tgt_freq_q >= cur_freq_q) begin
			fdiff_mag = DIFF_W'(tgt_freq_q - cur_freq_q);
		end else begin
			fdiff_mag = DIFF_W'(cur_freq_q - tgt_freq_q);
			fdiff_neg = 1'b1;
		end
	end

	assign mul_done   = (mul_b_q == '0);
	assign snap_start = (same_dir && (tgt_speed_q == cur_speed_q)) || (accel_q == '0);

	// round half up: the denominator still sits in the product register
	assign round_up  = ({div_rem, 1'b0} >= {1'b0, mul_acc_q});
	assign steps_new = div_quot + STEP_W'(round_up);

	assign ms_next = ms_elapsed_q + PERIOD_W'(1);

	// one ramp step: add in the same direction, subtract across a reversal
	assign cur_ext  = FSUM_W'(cur_freq_q);
	assign inc_ext  = {step_incr_q[INCR_W-1], step_incr_q};
	assign fsum_new = same_dir ? (cur_ext + inc_ext) : (cur_ext - inc_ext);
	assign fsum_mag = fsum_q[FSUM_W-1] ? (FSUM_W'(0) - fsum_q) : fsum_q;
	assign fsum_sat = (fsum_mag[FSUM_W-1:FREQ_W] != '0) ? FREQ_MAX : fsum_mag[FREQ_W-1:0];
	assign last_step = (step_index_q == step_total_q);

	assign incr_mag  = INCR_W'(div_quot[DIFF_W-1:0]);
	assign speed_sat = (div_quot[DIV_W-1:SPD_W] != '0) ? SPEED_MAX : div_quot[SPD_W-1:0];

	// divider requests
	always_comb begin
		div_start = 1'b0;
		div_numer = num_q;
		div_denom = mul_acc_q;
		case (state_q)
			ST_MUL_DEN: begin
				div_start = mul_done;
			end
			ST_DIV_STEPS: begin
				div_start = div_done && (steps_new != '0);
				div_numer = DIV_W'(fdiff_mag);
				div_denom = steps_new;
			end
			ST_TICK_FREQ: begin
				div_start = !last_step;
				div_numer = DIV_W'(fsum_sat);
				div_denom = DIV_W'(micro_eff);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	srmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// control and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			m_tvalid_q   <= 1'b0;
			micro_q      <= MICRO_W'(16);
			period_q     <= PERIOD_W'(10);
			cur_freq_q   <= '0;
			cur_dir_q    <= 1'b0;
			cur_speed_q  <= '0;
			tgt_freq_q   <= '0;
			tgt_speed_q  <= '0;
			tgt_dir_q    <= 1'b0;
			step_incr_q  <= '0;
			step_total_q <= '0;
			step_index_q <= '0;
			ms_elapsed_q <= '0;
			done_q       <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MICROSTEPS: micro_q  <= cfg_data[MICRO_W-1:0];
					CFG_PERIOD:     period_q <= cfg_data[PERIOD_W-1:0];
					default:        micro_q  <= micro_q;
				endcase
			end

			// output register: loaded from ST_OUT, emptied when the result is taken
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op_start) begin
							tgt_dir_q    <= raw_speed[TGT_W-1];
							tgt_speed_q  <= tgt_speed_in;
							step_index_q <= '0;
							ms_elapsed_q <= '0;
							done_q       <= 1'b0;
							state_q      <= ST_MUL_CUR;
						end else if (done_q) begin
							state_q <= ST_OUT;
						end else if (ms_next >= period_eff) begin
							ms_elapsed_q <= '0;
							step_index_q <= step_index_q + STEP_W'(1);
							state_q      <= ST_TICK_FREQ;
						end else begin
							ms_elapsed_q <= ms_next;
							state_q      <= ST_OUT;
						end
					end
				end
				ST_MUL_CUR: begin
					if (mul_done) begin
						cur_freq_q <= mul_acc_q[FREQ_W-1:0];
						state_q    <= ST_MUL_TGT;
					end
				end
				ST_MUL_TGT: begin
					if (mul_done) begin
						tgt_freq_q <= mul_acc_q[FREQ_W-1:0];
						if (snap_start) begin
							cur_freq_q  <= mul_acc_q[FREQ_W-1:0];
							cur_speed_q <= tgt_speed_q;
							cur_dir_q   <= tgt_dir_q;
							done_q      <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_MUL_DV;
						end
					end
				end
				ST_MUL_DV: begin
					if (mul_done) begin
						state_q <= ST_MUL_DEN;
					end
				end
				ST_MUL_DEN: begin
					if (mul_done) begin
						state_q <= ST_DIV_STEPS;
					end
				end
				ST_DIV_STEPS: begin
					if (div_done) begin
						if (steps_new == '0) begin
							cur_freq_q  <= tgt_freq_q;
							cur_speed_q <= tgt_speed_q;
							cur_dir_q   <= tgt_dir_q;
							done_q      <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							step_total_q <= steps_new;
							state_q      <= ST_DIV_INCR;
						end
					end
				end
				ST_DIV_INCR: begin
					if (div_done) begin
						step_incr_q <= diff_neg_q ? (INCR_W'(0) - incr_mag) : incr_mag;
						state_q     <= ST_OUT;
					end
				end
				ST_TICK_FREQ: begin
					if (last_step) begin
						// final step lands exactly on the target
						cur_freq_q  <= tgt_freq_q;
						cur_speed_q <= tgt_speed_q;
						cur_dir_q   <= tgt_dir_q;
						done_q      <= 1'b1;
						state_q     <= ST_OUT;
					end else begin
						cur_freq_q <= fsum_sat;
						if (fsum_q[FSUM_W-1]) begin
							cur_dir_q <= ~cur_dir_q;
						end
						state_q <= ST_TICK_SPEED;
					end
				end
				ST_TICK_SPEED: begin
					if (div_done) begin
						cur_speed_q <= speed_sat;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// shift-add multiplier and result payload
	always_ff @(posedge clk) begin
		if (mul_b_q != '0) begin
			if (mul_b_q[0]) begin
				mul_acc_q <= mul_acc_q + mul_a_q;
			end
			mul_a_q <= {mul_a_q[MUL_W-2:0], 1'b0};
			mul_b_q <= {1'b0, mul_b_q[MULB_W-1:1]};
		end

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					before_q <= cur_freq_q;
					accel_q  <= s_tdata[TGT_W +: ACCEL_W];
					fsum_q   <= fsum_new;
					if (op_start) begin
						mul_a_q   <= MUL_W'(cur_speed_q);
						mul_b_q   <= MULB_W'(micro_eff);
						mul_acc_q <= '0;
					end
				end
			end
			ST_MUL_CUR: begin
				if (mul_done) begin
					mul_a_q   <= MUL_W'(tgt_speed_q);
					mul_b_q   <= MULB_W'(micro_eff);
					mul_acc_q <= '0;
				end
			end
			ST_MUL_TGT: begin
				if (mul_done) begin
					mul_a_q   <= MUL_W'(dv);
					mul_b_q   <= MS_PER_S;
					mul_acc_q <= '0;
				end
			end
			ST_MUL_DV: begin
				if (mul_done) begin
					num_q     <= mul_acc_q;
					mul_a_q   <= MUL_W'(accel_q);
					mul_b_q   <= MULB_W'(period_eff);
					mul_acc_q <= '0;
				end
			end
			ST_DIV_STEPS: begin
				if (div_done) begin
					diff_neg_q <= fdiff_neg;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_freq_q <= cur_freq_q;
					out_dir_q  <= cur_dir_q;
					out_done_q <= done_q;
					out_upd_q  <= (cur_freq_q != before_q);
				end
			end
			default: begin
				num_q <= num_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_upd_q, out_done_q, out_dir_q, out_freq_q};

endmodule
`default_nettype wire
